>>> hw/rtl/grid_astar_path_search_unit_macros.svh
// Assertion macros for the grid A* search unit.
// Each expects clk and rst_n in scope where it is used.
`ifndef GRID_ASTAR_PATH_SEARCH_UNIT_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_UNIT_MACROS_SVH

// same-cycle implication
`define GASP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GASP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/gasp_pkg.sv
// Shared types and constants of the grid A* search unit.
// No dependencies.
package gasp_pkg;

    // cell state codes
    localparam logic [2:0] CELL_EMPTY    = 3'd0;
    localparam logic [2:0] CELL_OBSTACLE = 3'd1;
    localparam logic [2:0] CELL_QUEUED   = 3'd2;
    localparam logic [2:0] CELL_EXPANDED = 3'd3;
    localparam logic [2:0] CELL_START    = 3'd4;
    localparam logic [2:0] CELL_GOAL     = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_ROWS_IN_USE = 3'd0;
    localparam logic [2:0] REG_COLS_IN_USE = 3'd1;
    localparam logic [2:0] REG_START_ROW   = 3'd2;
    localparam logic [2:0] REG_START_COL   = 3'd3;
    localparam logic [2:0] REG_GOAL_ROW    = 3'd4;
    localparam logic [2:0] REG_GOAL_COL    = 3'd5;

    localparam int OUT_LIMIT = 16;

    // neighbour order: up, left, down, right
    localparam logic signed [1:0] DIR_DR [4] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0};
    localparam logic signed [1:0] DIR_DC [4] = '{2'sd0, -2'sd1, 2'sd0, 2'sd1};

    typedef struct packed {
        logic [3:0] r;
        logic [3:0] c;
        logic [7:0] g;
        logic [4:0] h;
    } open_entry_t;

    // one word of an open-list scan into the compare unit
    typedef struct packed {
        logic        valid;
        open_entry_t entry;
    } scan_in_t;

    // pending read-modify-write of one cell
    typedef struct packed {
        logic [3:0] r;
        logic [3:0] c;
        logic [2:0] val;
        logic       only_empty;
        logic       push;
        logic [7:0] g;
    } mark_t;

endpackage

>>> hw/rtl/gasp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gasp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/gasp_fmin.sv
// Shared compare unit: tracks the least g+h over an open-list scan.
// Depends on gasp_pkg. Ties go to the later entry.
module gasp_fmin
    import gasp_pkg::*;
#(
    parameter int IDX_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  scan_in_t         scan,
    input  logic [IDX_W-1:0] scan_idx,
    output logic [IDX_W-1:0] best_idx,
    output open_entry_t      best_entry
);
    logic             have_reg, have_next;
    logic [8:0]       best_f_reg, best_f_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    open_entry_t      best_entry_reg, best_entry_next;
    logic [8:0]       f;

    always_comb
    begin
        f               = 9'(scan.entry.g) + 9'(scan.entry.h);
        have_next       = have_reg;
        best_f_next     = best_f_reg;
        best_idx_next   = best_idx_reg;
        best_entry_next = best_entry_reg;
        if (clear)
        begin
            have_next = 1'b0;
        end
        else if (scan.valid && (!have_reg || f <= best_f_reg))
        begin
            have_next       = 1'b1;
            best_f_next     = f;
            best_idx_next   = scan_idx;
            best_entry_next = scan.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_f_reg     <= best_f_next;
        best_idx_reg   <= best_idx_next;
        best_entry_reg <= best_entry_next;
    end

    assign best_idx   = best_idx_reg;
    assign best_entry = best_entry_reg;
endmodule

>>> hw/rtl/grid_astar_path_search_unit.sv
// Grid A* search: row loads are taken only while idle; the last row starts the search.
// Search: old marks are first cleared row by row, then each expansion scans and compacts
// the open list (one open-list RAM, one compare unit).
// Results: each row is read, loaded and held until taken; no new request meanwhile.
// Reset (async, active low) clears control; cell rows read empty via row valid bits.
module grid_astar_path_search_unit
    import gasp_pkg::*;
#(
    parameter int GRID_ROWS  = 16,
    parameter int GRID_COLS  = 16,
    parameter int OPEN_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    // row load requests
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  load_row,
    input  logic [15:0] obstacle_mask,
    input  logic        final_row,
    // result requests
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  out_row,
    output logic [47:0] row_states,
    output logic        path_found,
    output logic        last_result
);
    `include "grid_astar_path_search_unit_macros.svh"

    localparam int RW     = GRID_ROWS > 1 ? $clog2(GRID_ROWS) : 1;
    localparam int OW     = OPEN_DEPTH > 1 ? $clog2(OPEN_DEPTH) : 1;
    localparam int CW     = $clog2(OPEN_DEPTH + 1);
    localparam int CELL_W = 3 * GRID_COLS;
    localparam int OUTC   = GRID_COLS < OUT_LIMIT ? GRID_COLS : OUT_LIMIT;
    localparam int ROWLIM = GRID_ROWS < OUT_LIMIT ? GRID_ROWS : OUT_LIMIT;
    localparam int COLLIM = OUTC;

    // sequencer states
    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_CLR_RD   = 16'h0002,
        S_CLR_WR   = 16'h0004,
        S_START    = 16'h0008,
        S_MK_RD    = 16'h0010,
        S_MK_WR    = 16'h0020,
        S_SCAN0    = 16'h0040,
        S_SCAN     = 16'h0080,
        S_MOVE     = 16'h0100,
        S_EXPAND   = 16'h0200,
        S_GOAL1    = 16'h0400,
        S_GOAL2    = 16'h0800,
        S_NBR      = 16'h1000,
        S_OUT_RD   = 16'h2000,
        S_OUT_LD   = 16'h4000,
        S_OUT_WAIT = 16'h8000
    } state_t;

    // ---- cell helpers ----
    function automatic logic [RW-1:0] row_idx(input logic [3:0] r);
        logic [RW+3:0] w;
        w = {{RW{1'b0}}, r};
        return w[RW-1:0];
    endfunction

    function automatic logic [2:0] get_cell(input logic [CELL_W-1:0] row,
                                            input logic [3:0] c);
        logic [2:0] v;
        v = CELL_EMPTY;
        for (int j = 0; j < GRID_COLS; j++)
        begin
            if (6'(j) == {2'b00, c})
            begin
                v = row[3*j +: 3];
            end
        end
        return v;
    endfunction

    function automatic logic [CELL_W-1:0] set_cell(input logic [CELL_W-1:0] row,
                                                   input logic [3:0] c,
                                                   input logic [2:0] v);
        logic [CELL_W-1:0] w;
        w = row;
        for (int j = 0; j < GRID_COLS; j++)
        begin
            if (6'(j) == {2'b00, c})
            begin
                w[3*j +: 3] = v;
            end
        end
        return w;
    endfunction

    // run start: everything but obstacles goes back to empty
    function automatic logic [CELL_W-1:0] keep_obst(input logic [CELL_W-1:0] row);
        logic [CELL_W-1:0] w;
        for (int j = 0; j < GRID_COLS; j++)
        begin
            w[3*j +: 3] = (row[3*j +: 3] == CELL_OBSTACLE) ? CELL_OBSTACLE : CELL_EMPTY;
        end
        return w;
    endfunction

    function automatic logic [CELL_W-1:0] load_cells(input logic [15:0] mask);
        logic [CELL_W-1:0] w;
        w = '0;
        for (int j = 0; j < OUTC; j++)
        begin
            w[3*j +: 3] = mask[j] ? CELL_OBSTACLE : CELL_EMPTY;
        end
        return w;
    endfunction

    function automatic logic [47:0] pack_row(input logic [CELL_W-1:0] row,
                                             input logic [4:0] cols);
        logic [47:0] w;
        w = '0;
        for (int j = 0; j < OUTC; j++)
        begin
            if (5'(j) < cols)
            begin
                w[3*j +: 3] = row[3*j +: 3];
            end
        end
        return w;
    endfunction

    function automatic logic [4:0] clamp_dim(input logic [4:0] v, input logic [4:0] lim);
        logic [4:0] t;
        t = (v == 5'd0) ? 5'd1 : v;
        if (t > lim)
        begin
            t = lim;
        end
        return t;
    endfunction

    function automatic logic [3:0] dist4(input logic [3:0] a, input logic [3:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // ---- registers ----
    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    logic [4:0]       cfg_rows_reg, cfg_rows_next;
    logic [4:0]       cfg_cols_reg, cfg_cols_next;
    logic [3:0]       start_row_reg, start_row_next;
    logic [3:0]       start_col_reg, start_col_next;
    logic [3:0]       goal_row_reg, goal_row_next;
    logic [3:0]       goal_col_reg, goal_col_next;
    logic [4:0]       run_rows_reg, run_rows_next;
    logic [4:0]       run_cols_reg, run_cols_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [RW-1:0]    clr_row_reg, clr_row_next;
    mark_t            mk_reg, mk_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic             pend_reg, pend_next;
    logic [CW-1:0]    pend_idx_reg, pend_idx_next;
    open_entry_t      cur_reg, cur_next;
    logic [2:0]       k_reg, k_next;
    logic [3:0]       out_ptr_reg, out_ptr_next;
    logic [GRID_ROWS-1:0] vld_reg, vld_next;
    logic [RW-1:0]    raddr_q_reg;
    logic             out_valid_reg, out_valid_next;
    logic [3:0]       out_row_reg, out_row_next;
    logic [47:0]      row_states_reg, row_states_next;
    logic             path_found_reg, path_found_next;
    logic             last_result_reg, last_result_next;

    // ---- memory ports ----
    logic              cell_we;
    logic [RW-1:0]     cell_waddr, cell_raddr;
    logic [CELL_W-1:0] cell_wdata, cell_q, cell_rdata;
    logic              open_we;
    logic [OW-1:0]     open_waddr, open_raddr;
    open_entry_t       open_wdata, open_q;
    logic              fm_clear;
    scan_in_t          fm_in;
    logic [CW-1:0]     fm_best_idx;
    open_entry_t       fm_best;

    // scratch
    logic              in_acc, out_acc, doit;
    logic [2:0]        cell_st;
    logic signed [5:0] nr, nc;

    gasp_ram #(.WIDTH(CELL_W), .DEPTH(GRID_ROWS)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_q)
    );

    gasp_ram #(.WIDTH($bits(open_entry_t)), .DEPTH(OPEN_DEPTH)) u_open_ram (
        .clk   (clk),
        .we    (open_we),
        .waddr (open_waddr),
        .wdata (open_wdata),
        .raddr (open_raddr),
        .rdata (open_q)
    );

    gasp_fmin #(.IDX_W(CW)) u_fmin (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (fm_clear),
        .scan       (fm_in),
        .scan_idx   (pend_idx_reg),
        .best_idx   (fm_best_idx),
        .best_entry (fm_best)
    );

    // a row never written reads as all empty
    assign cell_rdata = vld_reg[raddr_q_reg] ? cell_q : '0;

    assign in_stall    = (state_reg != S_IDLE);
    assign in_acc      = in_valid && !in_stall;
    assign out_acc     = out_valid_reg && !out_stall;
    assign out_valid   = out_valid_reg;
    assign out_row     = out_row_reg;
    assign row_states  = row_states_reg;
    assign path_found  = path_found_reg;
    assign last_result = last_result_reg;

    always_comb
    begin
        state_next       = state_reg;
        ret_next         = ret_reg;
        cfg_rows_next    = cfg_rows_reg;
        cfg_cols_next    = cfg_cols_reg;
        start_row_next   = start_row_reg;
        start_col_next   = start_col_reg;
        goal_row_next    = goal_row_reg;
        goal_col_next    = goal_col_reg;
        run_rows_next    = run_rows_reg;
        run_cols_next    = run_cols_reg;
        count_next       = count_reg;
        clr_row_next     = clr_row_reg;
        mk_next          = mk_reg;
        ptr_next         = ptr_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        cur_next         = cur_reg;
        k_next           = k_reg;
        out_ptr_next     = out_ptr_reg;
        vld_next         = vld_reg;
        out_valid_next   = out_valid_reg;
        out_row_next     = out_row_reg;
        row_states_next  = row_states_reg;
        path_found_next  = path_found_reg;
        last_result_next = last_result_reg;

        cell_we    = 1'b0;
        cell_waddr = '0;
        cell_wdata = '0;
        cell_raddr = '0;
        open_we    = 1'b0;
        open_waddr = '0;
        open_wdata = '0;
        open_raddr = '0;
        fm_clear   = 1'b0;
        fm_in      = '{valid: 1'b0, entry: open_q};
        doit       = 1'b0;
        cell_st    = get_cell(cell_rdata, mk_reg.c);
        nr         = $signed({2'b00, cur_reg.r}) + 6'(DIR_DR[k_reg[1:0]]);
        nc         = $signed({2'b00, cur_reg.c}) + 6'(DIR_DC[k_reg[1:0]]);

        // configuration, to be written only while idle; the block does not enforce this
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS_IN_USE: cfg_rows_next  = cfg_data;
                REG_COLS_IN_USE: cfg_cols_next  = cfg_data;
                REG_START_ROW:   start_row_next = cfg_data[3:0];
                REG_START_COL:   start_col_next = cfg_data[3:0];
                REG_GOAL_ROW:    goal_row_next  = cfg_data[3:0];
                REG_GOAL_COL:    goal_col_next  = cfg_data[3:0];
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    // rows beyond the grid are dropped
                    if (int'(load_row) < GRID_ROWS)
                    begin
                        cell_we    = 1'b1;
                        cell_waddr = row_idx(load_row);
                        cell_wdata = load_cells(obstacle_mask);
                    end
                    if (final_row)
                    begin
                        count_next    = '0;
                        run_rows_next = clamp_dim(cfg_rows_reg, 5'(ROWLIM));
                        run_cols_next = clamp_dim(cfg_cols_reg, 5'(COLLIM));
                        clr_row_next  = '0;
                        state_next    = S_CLR_RD;
                    end
                end
            end
            S_CLR_RD:
            begin
                cell_raddr = clr_row_reg;
                state_next = S_CLR_WR;
            end
            S_CLR_WR:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_row_reg;
                cell_wdata = keep_obst(cell_rdata);
                if (clr_row_reg == RW'(GRID_ROWS - 1))
                begin
                    state_next = S_START;
                end
                else
                begin
                    clr_row_next = clr_row_reg + 1'b1;
                    state_next   = S_CLR_RD;
                end
            end
            S_START:
            begin
                if ({1'b0, start_row_reg} >= run_rows_reg ||
                    {1'b0, start_col_reg} >= run_cols_reg ||
                    {1'b0, goal_row_reg}  >= run_rows_reg ||
                    {1'b0, goal_col_reg}  >= run_cols_reg)
                begin
                    out_valid_next   = 1'b1;
                    out_row_next     = '0;
                    row_states_next  = '0;
                    path_found_next  = 1'b0;
                    last_result_next = 1'b1;
                    state_next       = S_OUT_WAIT;
                end
                else
                begin
                    // start is queued even when it sits on an obstacle
                    mk_next = '{r: start_row_reg, c: start_col_reg, val: CELL_QUEUED,
                                only_empty: 1'b0, push: 1'b1, g: 8'd0};
                    ret_next   = S_SCAN0;
                    state_next = S_MK_RD;
                end
            end
            S_MK_RD:
            begin
                cell_raddr = row_idx(mk_reg.r);
                state_next = S_MK_WR;
            end
            S_MK_WR:
            begin
                doit = !mk_reg.only_empty || (cell_st == CELL_EMPTY);
                if (doit)
                begin
                    cell_we    = 1'b1;
                    cell_waddr = row_idx(mk_reg.r);
                    cell_wdata = set_cell(cell_rdata, mk_reg.c, mk_reg.val);
                    // full list: the cell is marked but not stored
                    if (mk_reg.push && count_reg < CW'(OPEN_DEPTH))
                    begin
                        open_we    = 1'b1;
                        open_waddr = count_reg[OW-1:0];
                        open_wdata = '{r: mk_reg.r, c: mk_reg.c, g: mk_reg.g,
                                       h: 5'(dist4(mk_reg.r, goal_row_reg)) +
                                          5'(dist4(mk_reg.c, goal_col_reg))};
                        count_next = count_reg + 1'b1;
                    end
                end
                state_next = ret_reg;
            end
            S_SCAN0:
            begin
                if (count_reg == '0)
                begin
                    out_valid_next   = 1'b1;
                    out_row_next     = '0;
                    row_states_next  = '0;
                    path_found_next  = 1'b0;
                    last_result_next = 1'b1;
                    state_next       = S_OUT_WAIT;
                end
                else
                begin
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    fm_clear   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // one entry read per cycle, compared in the next cycle
                fm_in.valid = pend_reg;
                if (ptr_reg < count_reg)
                begin
                    open_raddr    = ptr_reg[OW-1:0];
                    ptr_next      = ptr_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        cur_next   = fm_best;
                        ptr_next   = fm_best_idx + 1'b1;
                        state_next = S_MOVE;
                    end
                end
            end
            S_MOVE:
            begin
                // close the gap: entry i+1 moves down to i, order kept
                if (pend_reg)
                begin
                    open_we    = 1'b1;
                    open_waddr = OW'(pend_idx_reg - 1'b1);
                    open_wdata = open_q;
                end
                if (ptr_reg < count_reg)
                begin
                    open_raddr    = ptr_reg[OW-1:0];
                    ptr_next      = ptr_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        mk_next = '{r: cur_reg.r, c: cur_reg.c, val: CELL_EXPANDED,
                                    only_empty: 1'b0, push: 1'b0, g: cur_reg.g};
                        ret_next   = S_EXPAND;
                        state_next = S_MK_RD;
                    end
                end
            end
            S_EXPAND:
            begin
                if (cur_reg.r == goal_row_reg && cur_reg.c == goal_col_reg)
                begin
                    mk_next = '{r: start_row_reg, c: start_col_reg, val: CELL_START,
                                only_empty: 1'b0, push: 1'b0, g: 8'd0};
                    ret_next   = S_GOAL1;
                    state_next = S_MK_RD;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_NBR;
                end
            end
            S_GOAL1:
            begin
                // goal mark last, so start equal to goal reports goal
                mk_next = '{r: goal_row_reg, c: goal_col_reg, val: CELL_GOAL,
                            only_empty: 1'b0, push: 1'b0, g: 8'd0};
                ret_next   = S_GOAL2;
                state_next = S_MK_RD;
            end
            S_GOAL2:
            begin
                out_ptr_next = '0;
                state_next   = S_OUT_RD;
            end
            S_NBR:
            begin
                if (k_reg == 3'd4)
                begin
                    state_next = S_SCAN0;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    if (!nr[5] && !nc[5] && nr[4:0] < run_rows_reg &&
                        nc[4:0] < run_cols_reg)
                    begin
                        mk_next = '{r: nr[3:0], c: nc[3:0], val: CELL_QUEUED,
                                    only_empty: 1'b1, push: 1'b1,
                                    g: cur_reg.g + 8'd1};
                        ret_next   = S_NBR;
                        state_next = S_MK_RD;
                    end
                end
            end
            S_OUT_RD:
            begin
                cell_raddr = row_idx(out_ptr_reg);
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                out_valid_next   = 1'b1;
                out_row_next     = out_ptr_reg;
                row_states_next  = pack_row(cell_rdata, run_cols_reg);
                path_found_next  = 1'b1;
                last_result_next = ({1'b0, out_ptr_reg} + 5'd1 == run_rows_reg);
                state_next       = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    if (last_result_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        out_ptr_next = out_ptr_reg + 1'b1;
                        state_next   = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cell_we)
        begin
            vld_next[cell_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ret_reg         <= S_IDLE;
            cfg_rows_reg    <= 5'd16;
            cfg_cols_reg    <= 5'd16;
            start_row_reg   <= '0;
            start_col_reg   <= '0;
            goal_row_reg    <= '0;
            goal_col_reg    <= '0;
            count_reg       <= '0;
            pend_reg        <= 1'b0;
            vld_reg         <= '0;
            raddr_q_reg     <= '0;
            out_valid_reg   <= 1'b0;
            last_result_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ret_reg         <= ret_next;
            cfg_rows_reg    <= cfg_rows_next;
            cfg_cols_reg    <= cfg_cols_next;
            start_row_reg   <= start_row_next;
            start_col_reg   <= start_col_next;
            goal_row_reg    <= goal_row_next;
            goal_col_reg    <= goal_col_next;
            count_reg       <= count_next;
            pend_reg        <= pend_next;
            vld_reg         <= vld_next;
            raddr_q_reg     <= cell_raddr;
            out_valid_reg   <= out_valid_next;
            last_result_reg <= last_result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_rows_reg   <= run_rows_next;
        run_cols_reg   <= run_cols_next;
        clr_row_reg    <= clr_row_next;
        mk_reg         <= mk_next;
        ptr_reg        <= ptr_next;
        pend_idx_reg   <= pend_idx_next;
        cur_reg        <= cur_next;
        k_reg          <= k_next;
        out_ptr_reg    <= out_ptr_next;
        out_row_reg    <= out_row_next;
        row_states_reg <= row_states_next;
        path_found_reg <= path_found_next;
    end

    `GASP_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(OPEN_DEPTH), "open list overfilled")
    `GASP_ASSERT_IMP(a_out_in_wait, out_valid_reg, state_reg == S_OUT_WAIT, "result outside wait")
    `GASP_ASSERT_IMP(a_move_nonempty, state_reg == S_MOVE, count_reg != '0, "removal from empty list")
    `GASP_ASSERT_NXT(a_last_to_idle, out_acc && last_result_reg, state_reg == S_IDLE, "run not closed")
    `GASP_ASSERT_NXT(a_final_clears, in_acc && final_row, state_reg == S_CLR_RD, "search not started")

endmodule

>>> test/grid_astar_path_search_unit_tb.sv
// Testbench of the grid A* search unit: row-load requests in, row-state results out.
// Uses gasp_pkg and grid_astar_path_search_unit; holds its own predictor of the search.
module grid_astar_path_search_unit_tb;
    import gasp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NR = 16;
    localparam int NC = 16;
    localparam int DEPTH = 256;
    localparam longint CYCLE_LIMIT = 64'd50000000;

    typedef struct {
        logic [3:0]  row;
        logic [47:0] states;
        logic        found;
        logic        last;
    } row_report_t;

    typedef struct {
        int r;
        int c;
        int g;
        int h;
    } frontier_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [4:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  load_row;
    logic [15:0] obstacle_mask;
    logic        final_row;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  out_row;
    logic [47:0] row_states;
    logic        path_found;
    logic        last_result;

    // predictor state
    logic [2:0]  grid_marks [NR*NC];
    frontier_t   frontier [DEPTH];
    int          frontier_len;
    int          rows_cfg, cols_cfg, st_r, st_c, gl_r, gl_c;

    row_report_t expected_rows [$];
    int          mismatches;
    longint      cycles;
    int          reports_seen;

    grid_astar_path_search_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .load_row(load_row), .obstacle_mask(obstacle_mask), .final_row(final_row),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_row(out_row), .row_states(row_states),
        .path_found(path_found), .last_result(last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // timeout guard
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic int clamp_size(int v);
        if (v == 0) return 1;
        if (v > 16) return 16;
        return v;
    endfunction

    function automatic int absdiff(int a, int b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic void enqueue_cell(int r, int c, int g);
        if (frontier_len < DEPTH)
        begin
            frontier[frontier_len] = '{r, c, g, absdiff(r, gl_r) + absdiff(c, gl_c)};
            frontier_len++;
        end
        grid_marks[r*NC + c] = CELL_QUEUED;
    endfunction

    // A* over the loaded grid; ties go to the entry queued latest
    function automatic bit search_grid(int rows, int cols);
        int best, bestf, f, nr, nc;
        frontier_t cur;
        for (int i = 0; i < NR*NC; i++)
            if (grid_marks[i] != CELL_OBSTACLE) grid_marks[i] = CELL_EMPTY;
        frontier_len = 0;
        if (st_r >= rows || st_c >= cols || gl_r >= rows || gl_c >= cols) return 0;
        enqueue_cell(st_r, st_c, 0);
        while (frontier_len > 0)
        begin
            best = 0;
            bestf = 0;
            for (int i = 0; i < frontier_len; i++)
            begin
                f = frontier[i].g + frontier[i].h;
                if (i == 0 || f <= bestf)
                begin
                    best = i;
                    bestf = f;
                end
            end
            cur = frontier[best];
            for (int i = best; i < frontier_len - 1; i++) frontier[i] = frontier[i+1];
            frontier_len--;
            grid_marks[cur.r*NC + cur.c] = CELL_EXPANDED;
            if (cur.r == gl_r && cur.c == gl_c)
            begin
                grid_marks[st_r*NC + st_c] = CELL_START;
                grid_marks[gl_r*NC + gl_c] = CELL_GOAL;
                return 1;
            end
            for (int k = 0; k < 4; k++)
            begin
                nr = cur.r + int'(DIR_DR[k]);
                nc = cur.c + int'(DIR_DC[k]);
                if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
                if (grid_marks[nr*NC + nc] != CELL_EMPTY) continue;
                enqueue_cell(nr, nc, cur.g + 1);
            end
        end
        return 0;
    endfunction

    // works out the row reports caused by one load request
    function automatic void predict_load(logic [3:0] lr, logic [15:0] mask, logic fin);
        int rows, cols;
        logic [47:0] packed_row;
        for (int c = 0; c < NC; c++)
            grid_marks[lr*NC + c] = mask[c] ? CELL_OBSTACLE : CELL_EMPTY;
        if (!fin) return;
        rows = clamp_size(rows_cfg);
        cols = clamp_size(cols_cfg);
        if (!search_grid(rows, cols))
        begin
            expected_rows = {expected_rows, row_report_t'{4'd0, 48'd0, 1'b0, 1'b1}};
            return;
        end
        for (int r = 0; r < rows; r++)
        begin
            packed_row = '0;
            for (int c = 0; c < cols; c++) packed_row[3*c +: 3] = grid_marks[r*NC + c];
            expected_rows = {expected_rows,
                             row_report_t'{4'(r), packed_row, 1'b1, r + 1 == rows}};
        end
    endfunction

    // result checker with random stall
    initial
    begin
        int waitc;
        row_report_t exp_r;
        out_stall = 1'b1;
        mismatches = 0;
        reports_seen = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            waitc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            out_stall = 1'b1;
            repeat (waitc) @(negedge clk);
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            reports_seen++;
            if (expected_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: row %0d states %h", out_row, row_states);
            end
            else
            begin
                exp_r = expected_rows.pop_front();
                if (out_row !== exp_r.row || row_states !== exp_r.states ||
                    path_found !== exp_r.found || last_result !== exp_r.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp row %0d %h f%0d l%0d, got %0d %h f%0d l%0d",
                                 exp_r.row, exp_r.states, exp_r.found, exp_r.last,
                                 out_row, row_states, path_found, last_result);
                end
            end
        end
    end

    // sends one load request, random gap first; prediction taken on acceptance
    task automatic send_load(logic [3:0] lr, logic [15:0] mask, logic fin);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        repeat (gap) @(negedge clk);
        in_valid = 1'b1;
        load_row = lr;
        obstacle_mask = mask;
        final_row = fin;
        do @(posedge clk); while (in_stall);
        predict_load(lr, mask, fin);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [4:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_ROWS_IN_USE: rows_cfg = val;
            REG_COLS_IN_USE: cols_cfg = val;
            REG_START_ROW:   st_r = val[3:0];
            REG_START_COL:   st_c = val[3:0];
            REG_GOAL_ROW:    gl_r = val[3:0];
            default:         gl_c = val[3:0];
        endcase
    endtask

    // the block is idle once every report is in and the search tail has passed
    task automatic wait_idle();
        while (expected_rows.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_search(int rows, int cols, int sr, int sc, int gr, int gc);
        wait_idle();
        write_reg(REG_ROWS_IN_USE, 5'(rows));
        write_reg(REG_COLS_IN_USE, 5'(cols));
        write_reg(REG_START_ROW, 5'(sr));
        write_reg(REG_START_COL, 5'(sc));
        write_reg(REG_GOAL_ROW, 5'(gr));
        write_reg(REG_GOAL_COL, 5'(gc));
    endtask

    // loads a whole grid of the given size; obstacle density as a 1-in-n chance
    task automatic load_grid(int rows, int density);
        logic [15:0] m;
        for (int r = 0; r < rows; r++)
        begin
            m = '0;
            for (int c = 0; c < 16; c++) m[c] = ($urandom_range(0, density - 1) == 0);
            send_load(4'(r), m, r == rows - 1);
        end
    endtask

    task automatic test_extremes();
        // default setting: start equal to goal at the corner
        send_load(4'd0, 16'h0000, 1'b1);
        // open full grid, corner to corner
        set_search(16, 16, 0, 0, 15, 15);
        for (int r = 0; r < 16; r++) send_load(4'(r), 16'h0000, r == 15);
        // start on an obstacle, goal walled off
        set_search(4, 4, 1, 1, 3, 3);
        send_load(4'd0, 16'h0000, 1'b0);
        send_load(4'd1, 16'hFFFF, 1'b0);
        send_load(4'd2, 16'h0008, 1'b0);
        send_load(4'd3, 16'h0004, 1'b1);
        // out-of-range sizes, start outside grid
        set_search(0, 31, 5, 0, 0, 0);
        send_load(4'd15, 16'hAAAA, 1'b1);
        set_search(1, 1, 0, 0, 0, 0);
        send_load(4'd0, 16'h5555, 1'b1);
        set_search(20, 0, 15, 0, 0, 0);
        send_load(4'd7, 16'h0000, 1'b1);
        // goal outside the grid in use
        set_search(3, 3, 0, 0, 3, 0);
        send_load(4'd0, 16'h0000, 1'b1);
    endtask

    task automatic test_random_searches();
        int rows, cols;
        for (int n = 0; n < 30; n++)
        begin
            rows = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(1, 8);
            cols = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(1, 8);
            if ($urandom_range(0, 9) == 0) rows = $urandom_range(0, 31);
            set_search(rows, cols, $urandom_range(0, clamp_size(rows) - 1),
                       $urandom_range(0, clamp_size(cols) - 1),
                       $urandom_range(0, clamp_size(rows) - 1),
                       $urandom_range(0, clamp_size(cols) - 1));
            if ($urandom_range(0, 5) == 0) send_load(4'($urandom), 16'($urandom), 1'b0);
            load_grid(clamp_size(rows), $urandom_range(2, 6));
        end
    endtask

    task automatic test_reruns();
        // repeated finals reuse the grid: old marks must be cleared
        set_search(8, 8, 7, 7, 0, 0);
        load_grid(8, 4);
        for (int n = 0; n < 6; n++)
            send_load(4'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
        set_search(8, 8, 0, 7, 7, 0);
        send_load(4'd3, 16'h0000, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ROWS_IN_USE;
        cfg_data = '0;
        in_valid = 1'b0;
        load_row = '0;
        obstacle_mask = '0;
        final_row = 1'b0;
        rows_cfg = 16;
        cols_cfg = 16;
        st_r = 0;
        st_c = 0;
        gl_r = 0;
        gl_c = 0;
        frontier_len = 0;
        for (int i = 0; i < NR*NC; i++) grid_marks[i] = CELL_EMPTY;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_extremes();
        test_random_searches();
        test_reruns();
        while (expected_rows.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (mismatches == 0 && expected_rows.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
